FILE: src/skns_pkg.sv
// Shared types and constants for the sorted key node store.
// Used by skns_cell and sorted_key_node_store; depends on nothing else.
package skns_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int SLOT_W  = 5;

    localparam logic FUNC_FIND   = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic take_new;   // load the broadcast key and value
        logic take_prev;  // load from the lower neighbor (shift up)
        logic sel;        // drive this cell's value onto the read bus
    } t_cell_ctl;

    // Registered compare of the broadcast key against the cell's key.
    typedef struct packed {
        logic eq;         // broadcast key equals cell key
        logic lt;         // broadcast key is below cell key
    } t_cell_flags;

endpackage

FILE: src/skns_cell.sv
// One storage cell of the sorted chain: a key, a value word and a compare unit.
// Depends on skns_pkg.
module skns_cell
    import skns_pkg::*;
#(
    parameter int VW = 32
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VW-1:0]     i_value,
    input  logic [KEY_W-1:0]  i_prev_key,
    input  logic [VW-1:0]     i_prev_value,
    output logic [KEY_W-1:0]  o_key,
    output logic [VW-1:0]     o_value,
    output logic [VW-1:0]     o_sel_value,
    output t_cell_flags       o_flags
);

    logic [KEY_W-1:0] r_key;
    logic [VW-1:0]    r_value;
    t_cell_flags      r_flags;

    always_ff @(posedge i_clk) begin
        if (i_ctl.take_new) begin
            r_key   <= i_key;
            r_value <= i_value;
        end else if (i_ctl.take_prev) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end
        r_flags.eq <= (i_key == r_key);
        r_flags.lt <= (i_key < r_key);
    end

    assign o_key       = r_key;
    assign o_value     = r_value;
    assign o_sel_value = i_ctl.sel ? r_value : '0;
    assign o_flags     = r_flags;

endmodule

FILE: src/sorted_key_node_store.sv
// Top level of the sorted key node store: search sequencer plus the cell chain.
// Depends on skns_pkg and skns_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request item: func
//   (find or insert), key and value word. Output channel (o_out_valid /
//   i_out_ready) returns one result item per request: found, position,
//   slot value, status and the cell count after the request.
//   Every cell compares its key with the request key in parallel; the
//   sequencer then runs the binary search over the registered compare
//   flags, one probe per cycle. An insert into a node that is not full shifts
//   all cells above the slot up by one at once, each cell taking its lower neighbor.
//   After the accept, a request passes through the prime, search, apply and
//   finish states; the search makes one probe per step until a hit, plus a
//   closing step when the key misses. At most clog2(MAX_CELLS + 1) probes are made.
//   One request is in work at a time; the next is taken as soon as the
//   previous result sits in the output register.
//   Reset clears the cell count and the handshake state; cell contents are
//   not cleared. If the receiver stalls, the result holds in the output
//   register and the sequencer waits with the next result until it drains.
module sorted_key_node_store
    import skns_pkg::*;
#(
    parameter int MAX_CELLS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [VALUE_W-1:0] i_value_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic [SLOT_W-1:0]  o_position,
    output logic [VALUE_W-1:0] o_slot_value,
    output logic               o_status,
    output logic [SLOT_W-1:0]  o_cell_count
);

    localparam int SW = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
    localparam int CW = $clog2(MAX_CELLS + 1);
    localparam int IW = $clog2(MAX_CELLS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME,
        S_SEARCH,
        S_APPLY,
        S_FINISH
    } t_state;

    t_state            r_state;
    logic              r_func;
    logic [KEY_W-1:0]  r_key;
    logic [SW-1:0]     r_value;
    logic [CW-1:0]     r_lo;
    logic [CW-1:0]     r_hi;
    logic [CW-1:0]     r_pos;
    logic              r_hit;
    logic [CW-1:0]     r_count;
    logic [SW-1:0]     r_sval;
    logic              r_stat;

    logic              r_out_valid;
    logic              r_o_found;
    logic [SLOT_W-1:0] r_o_position;
    logic [SW-1:0]     r_o_sval;
    logic              r_o_status;
    logic [SLOT_W-1:0] r_o_count;

    t_cell_ctl         cell_ctl   [MAX_CELLS];
    t_cell_flags       cell_flags [MAX_CELLS];
    logic [KEY_W-1:0]  cell_key   [MAX_CELLS];
    logic [SW-1:0]     cell_value [MAX_CELLS];
    logic [SW-1:0]     cell_sel   [MAX_CELLS];

    logic [CW:0]       mid_sum;
    logic [CW-1:0]     mid;
    logic [IW-1:0]     mid_idx;
    logic              do_shift;
    logic              load_out;
    logic [SW-1:0]     read_value;

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CW:1];
    assign mid_idx = mid[IW-1:0];

    assign do_shift = (r_state == S_APPLY) && (r_func == FUNC_INSERT) &&
                      (r_count < CW'(MAX_CELLS));

    assign load_out = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    always_comb begin
        for (int i = 0; i < MAX_CELLS; i++) begin
            cell_ctl[i].take_new  = do_shift && (CW'(i) == r_pos);
            cell_ctl[i].take_prev = do_shift && (CW'(i) > r_pos);
            cell_ctl[i].sel       = (CW'(i) == r_pos);
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_CELLS; g++) begin : g_cell
            logic [KEY_W-1:0] prev_key;
            logic [SW-1:0]    prev_value;
            if (g == 0) begin : g_head
                assign prev_key   = '0;
                assign prev_value = '0;
            end else begin : g_link
                assign prev_key   = cell_key[g-1];
                assign prev_value = cell_value[g-1];
            end
            skns_cell #(.VW(SW)) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl[g]),
                .i_key        (r_key),
                .i_value      (r_value),
                .i_prev_key   (prev_key),
                .i_prev_value (prev_value),
                .o_key        (cell_key[g]),
                .o_value      (cell_value[g]),
                .o_sel_value  (cell_sel[g]),
                .o_flags      (cell_flags[g])
            );
        end
    endgenerate

    always_comb begin
        read_value = '0;
        for (int i = 0; i < MAX_CELLS; i++) begin
            read_value = read_value | cell_sel[i];
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func  <= i_func;
                        r_key   <= i_key;
                        r_value <= i_value_word[SW-1:0];
                        r_state <= S_PRIME;
                    end
                end
                S_PRIME: begin
                    // cells latch their compare flags this cycle
                    r_lo    <= '0;
                    r_hi    <= r_count;
                    r_hit   <= 1'b0;
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    if (r_lo == r_hi) begin
                        r_pos   <= r_lo;
                        r_state <= S_APPLY;
                    end else if (cell_flags[mid_idx].eq) begin
                        r_pos   <= mid;
                        r_hit   <= 1'b1;
                        r_state <= S_APPLY;
                    end else if (cell_flags[mid_idx].lt) begin
                        r_hi <= mid;
                    end else begin
                        r_lo <= mid + 1'b1;
                    end
                end
                S_APPLY: begin
                    if (r_func == FUNC_FIND) begin
                        r_sval <= r_hit ? read_value : '0;
                        r_stat <= STATUS_DONE;
                    end else if (r_count >= CW'(MAX_CELLS)) begin
                        r_sval <= '0;
                        r_stat <= STATUS_FULL;
                    end else begin
                        r_sval  <= '0;
                        r_stat  <= STATUS_DONE;
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    // hold until the output register is free
                    if (load_out) begin
                        r_o_found    <= r_hit;
                        r_o_position <= SLOT_W'(r_pos);
                        r_o_sval     <= r_sval;
                        r_o_status   <= r_stat;
                        r_o_count    <= SLOT_W'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_o_found;
    assign o_position   = r_o_position;
    assign o_slot_value = VALUE_W'(r_o_sval);
    assign o_status     = r_o_status;
    assign o_cell_count = r_o_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_CELLS))
        else $error("cell count above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_FULL) |-> o_cell_count == SLOT_W'(MAX_CELLS))
        else $error("full status with node not full");

    a_find_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && r_func == FUNC_FIND) |=> r_count == $past(r_count))
        else $error("find changed the cell count");

    a_value_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_slot_value != '0) |-> (o_found && o_status == STATUS_DONE))
        else $error("slot value without a found key");

endmodule

FILE: sim/tb_sorted_key_node_store.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_key_node_store: directed requests, then random
// find and insert traffic with idling on both channels, checked against a sorted-node predictor.
// Depends on skns_pkg and the RTL of sorted_key_node_store.
module tb_sorted_key_node_store;
    import skns_pkg::*;

    localparam int NODE_CELLS    = 16;
    localparam int TOTAL_ITEMS   = 1300;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] position;
        logic [VALUE_W-1:0] slot_value;
        logic              status;
        logic [SLOT_W-1:0] cell_count;
    } t_node_result;

    class node_store_scoreboard;
        logic [KEY_W-1:0]   node_keys[NODE_CELLS];
        logic [VALUE_W-1:0] node_values[NODE_CELLS];
        int                 fill;
        t_node_result       pending_results[$];
        int                 failures;
        int                 finds;
        int                 inserts;
        int                 refusals;
        int                 checked;

        function new();
            fill = 0;
            failures = 0;
            finds = 0;
            inserts = 0;
            refusals = 0;
            checked = 0;
        endfunction

        // Binary search over the occupied cells, stopping at the first equal probe.
        function void locate_slot(input logic [KEY_W-1:0] k, output logic hit,
                                  output int slot);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = fill;
            hit = 1'b0;
            while (lo != hi) begin
                mid = (lo + hi) / 2;
                if (k == node_keys[mid]) begin
                    hit = 1'b1;
                    slot = mid;
                    return;
                end
                if (k < node_keys[mid]) hi = mid;
                else lo = mid + 1;
            end
            slot = lo;
        endfunction

        function void note_request(input logic func, input logic [KEY_W-1:0] k,
                                   input logic [VALUE_W-1:0] v);
            t_node_result exp;
            logic hit;
            int slot;
            locate_slot(k, hit, slot);
            exp = '0;
            exp.found = hit;
            exp.position = SLOT_W'(slot);
            exp.status = STATUS_DONE;
            if (func == FUNC_FIND) begin
                finds++;
                if (hit) exp.slot_value = node_values[slot];
            end else if (fill >= NODE_CELLS) begin
                refusals++;
                exp.status = STATUS_FULL;
            end else begin
                inserts++;
                for (int i = fill; i > slot; i--) begin
                    node_keys[i] = node_keys[i-1];
                    node_values[i] = node_values[i-1];
                end
                node_keys[slot] = k;
                node_values[slot] = v;
                fill++;
            end
            exp.cell_count = SLOT_W'(fill);
            pending_results.push_back(exp);
        endfunction

        function void check_result(input t_node_result got);
            t_node_result exp;
            checked++;
            if (pending_results.size() == 0) begin
                failures++;
                $display("%0t: unexpected result: found=%0b pos=%0d val=%h st=%0b cnt=%0d",
                         $time, got.found, got.position, got.slot_value, got.status,
                         got.cell_count);
                return;
            end
            exp = pending_results.pop_front();
            if (got.found !== exp.found) begin
                failures++;
                $display("%0t: found expected %0b actual %0b", $time, exp.found, got.found);
            end
            if (got.position !== exp.position) begin
                failures++;
                $display("%0t: position expected %0d actual %0d", $time, exp.position,
                         got.position);
            end
            if (got.slot_value !== exp.slot_value) begin
                failures++;
                $display("%0t: slot_value expected %h actual %h", $time, exp.slot_value,
                         got.slot_value);
            end
            if (got.status !== exp.status) begin
                failures++;
                $display("%0t: status expected %0b actual %0b", $time, exp.status, got.status);
            end
            if (got.cell_count !== exp.cell_count) begin
                failures++;
                $display("%0t: cell_count expected %0d actual %0d", $time, exp.cell_count,
                         got.cell_count);
            end
        endfunction

        // Favor keys already stored and their neighbors so hits and duplicates are common.
        function logic [KEY_W-1:0] pick_key();
            int roll;
            logic [KEY_W-1:0] k;
            roll = $urandom_range(0, 99);
            if (fill > 0 && roll < 40) begin
                k = node_keys[$urandom_range(0, fill - 1)];
            end else if (fill > 0 && roll < 60) begin
                k = node_keys[$urandom_range(0, fill - 1)];
                k = ($urandom_range(0, 1) != 0) ? k + 1 : k - 1;
            end else if (roll < 70) begin
                case ($urandom_range(0, 5))
                    0: k = '0;
                    1: k = 32'h0000_0001;
                    2: k = 32'h7FFF_FFFF;
                    3: k = 32'h8000_0000;
                    4: k = 32'hFFFF_FFFE;
                    default: k = '1;
                endcase
            end else begin
                k = $urandom();
            end
            return k;
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_func;
    logic [KEY_W-1:0]   i_key;
    logic [VALUE_W-1:0] i_value_word;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_found;
    logic [SLOT_W-1:0]  o_position;
    logic [VALUE_W-1:0] o_slot_value;
    logic               o_status;
    logic [SLOT_W-1:0]  o_cell_count;

    node_store_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int quiet_cycles;

    sorted_key_node_store #(
        .MAX_CELLS  (NODE_CELLS),
        .VALUE_WIDTH(VALUE_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_value_word(i_value_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_found     (o_found),
        .o_position  (o_position),
        .o_slot_value(o_slot_value),
        .o_status    (o_status),
        .o_cell_count(o_cell_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Check results before noting the request; a result never leaves in its own accept cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result({o_found, o_position, o_slot_value, o_status, o_cell_count});
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_request(i_func, i_key, i_value_word);
            end
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_request(input logic func, input logic [KEY_W-1:0] k,
                                input logic [VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= func;
        i_key        <= k;
        i_value_word <= v;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic run_directed();
        // Empty node: both key extremes miss at slot zero.
        send_request(FUNC_FIND, '0, 32'hA5A5_A5A5);
        send_request(FUNC_FIND, '1, 32'h5A5A_5A5A);
        // Key and value extremes, then equal keys to force the duplicate probe rule.
        send_request(FUNC_INSERT, 32'h8000_0000, 32'h1234_5678);
        send_request(FUNC_INSERT, '0, '1);
        send_request(FUNC_INSERT, '1, '0);
        send_request(FUNC_INSERT, 32'h8000_0000, 32'h5555_5555);
        send_request(FUNC_INSERT, 32'h8000_0000, 32'hAAAA_AAAA);
        send_request(FUNC_FIND, '0, '0);
        send_request(FUNC_FIND, '1, '1);
        send_request(FUNC_FIND, 32'h8000_0000, '0);
        send_request(FUNC_FIND, 32'h7FFF_FFFF, '1);
        send_request(FUNC_FIND, 32'h8000_0001, '0);
        send_request(FUNC_FIND, 32'h0000_0001, '0);
        send_request(FUNC_FIND, 32'hFFFF_FFFE, '1);
    endtask

    initial begin
        int sent;
        logic func;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_func       = FUNC_FIND;
        i_key        = '0;
        i_value_word = '0;
        i_out_ready  = 1'b0;
        quiet_cycles = 0;
        tx_idle_pct  = 31;
        rx_idle_pct  = 61;
        sb = new();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        sent = 14;
        while (sent < TOTAL_ITEMS) begin
            if (sent == TOTAL_ITEMS / 3) begin
                tx_idle_pct = 61;
                rx_idle_pct = 31;
            end else if (sent == 2 * TOTAL_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // Fill slowly so shifts land across idle phases; once full, retry inserts often.
            if (sb.fill < NODE_CELLS) begin
                func = ($urandom_range(0, 99) < 3) ? FUNC_INSERT : FUNC_FIND;
            end else begin
                func = ($urandom_range(0, 99) < 30) ? FUNC_INSERT : FUNC_FIND;
            end
            send_request(func, sb.pick_key(), $urandom());
            sent++;
        end
        i_in_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests: %0d finds, %0d inserts stored, %0d refused when full",
                 sent, sb.finds, sb.inserts, sb.refusals);
        $display("Checked %0d results, %0d field errors", sb.checked, sb.failures);
        if (sb.failures == 0 && sb.pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
